FILE: rtl/core/fea_pkg.sv
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types and constants of the fiber excitation automaton.
// ----------------------------------------------------------------------------
package fea_pkg;

	localparam int MaxNodes    = 1024;
	localparam int MaxElements = 1024;
	localparam int TimerBits   = 16;
	localparam int NodeBits    = $clog2(MaxNodes);
	localparam int ElemBits    = $clog2(MaxElements);
	localparam int CountBits   = 11;
	localparam int CfgIdxBits  = 3;
	localparam int CfgDataBits = 16;
	localparam logic [16:0] HitQ16 = 17'd64881;

	typedef enum logic [1:0] {
		MODE_LOAD_NODE = 2'd0,
		MODE_LOAD_ELEM = 2'd1,
		MODE_TICK      = 2'd2,
		MODE_READ      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_NODE_COUNT = 3'd0,
		REG_ELEM_COUNT = 3'd1,
		REG_APD        = 3'd2,
		REG_ERP        = 3'd3,
		REG_PERIOD     = 3'd4,
		REG_SPEED      = 3'd5,
		REG_BLOCK_EN   = 3'd6,
		REG_BLOCK_NODE = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_PACE_RD,
		ST_PACE_WR,
		ST_EL_RD,
		ST_EL_NODE_RD,
		ST_EL_EVAL,
		ST_EL_FIRE,
		ST_NODE_RD,
		ST_NODE_WR,
		ST_READ_RD,
		ST_READ_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic [NodeBits-1:0]  node_index;
		logic                 pacing_site;
		logic [ElemBits-1:0]  element_index;
		logic [NodeBits-1:0]  end_a;
		logic [NodeBits-1:0]  end_b;
		logic [15:0]          element_length;
	} in_item_t;

	typedef struct packed {
		logic                 depolarized;
		logic                 refractory;
		logic [15:0]          timer;
		logic                 too_fast;
		logic [15:0]          conflicts;
	} out_item_t;

endpackage

FILE: rtl/core/fea_stream_if.sv
// ----------------------------------------------------------------------------
// fea_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface fea_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/fiber_excitation_automaton_top.sv
// ----------------------------------------------------------------------------
// fiber_excitation_automaton_top
// Excitation automaton, fiber mesh of two-node elements, node/elem state in RAM.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass zeroes the node and progress
// memories; no item is taken meanwhile. Node load and read go through the
// ST_READ_RD and ST_READ_WR states. Element load runs the 32-step bit-serial
// divider of speed*65536/length. Tick: a pacing pass over the node_count nodes
// (only when the pace counter is zero), an element walk over the element_count
// elements (one RAM port per node table, one more state for each element that
// reaches the end) and a timer pass over the node_count nodes.
// The result waits in an output register; the next item is taken once the
// result has been transferred.
module fiber_excitation_automaton_top (
	input  logic clk,
	input  logic arst_n,
	fea_stream_if.sink   in_ch,
	fea_stream_if.source out_ch,
	input  logic                          cfg_we,
	input  logic [fea_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [fea_pkg::CfgDataBits-1:0] cfg_data
);
	import fea_pkg::*;

	// node word: focus, depol, refr, ticks
	localparam int NW = 3 + TimerBits;
	localparam int EW = 2*NodeBits + 16;

	logic [CountBits-1:0] node_count_q, elem_count_q;
	logic [15:0] apd_q, erp_q, period_q, speed_q;
	logic        blk_en_q;
	logic [NodeBits-1:0] blk_node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CountBits'(1024);
			elem_count_q <= '0;
			apd_q <= 16'd50;
			erp_q <= 16'd100;
			period_q <= 16'd1000;
			speed_q <= 16'd1;
			blk_en_q <= 1'b0;
			blk_node_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NODE_COUNT: node_count_q <= cfg_data[CountBits-1:0];
				REG_ELEM_COUNT: elem_count_q <= cfg_data[CountBits-1:0];
				REG_APD:        apd_q <= cfg_data;
				REG_ERP:        erp_q <= cfg_data;
				REG_PERIOD:     period_q <= cfg_data;
				REG_SPEED:      speed_q <= cfg_data;
				REG_BLOCK_EN:   blk_en_q <= cfg_data[0];
				REG_BLOCK_NODE: blk_node_q <= cfg_data[NodeBits-1:0];
				default: ;
			endcase
		end
	end

	// memories
	logic [NW-1:0] node_mem [MaxNodes];
	logic [EW-1:0] elem_mem [MaxElements];
	logic [16:0]   prog_mem [MaxElements];

	logic                n_we;
	logic [NodeBits-1:0] n_addr;
	logic [NW-1:0]       n_wdata, n_rdata;
	logic                e_we;
	logic [ElemBits-1:0] e_waddr, e_raddr;
	logic [EW-1:0]       e_wdata, e_rdata;
	logic                p_we;
	logic [ElemBits-1:0] p_waddr;
	logic [16:0]         p_wdata, p_rdata;

	always_ff @(posedge clk) begin
		if (n_we) node_mem[n_addr] <= n_wdata;
		n_rdata <= node_mem[n_addr];
		if (e_we) elem_mem[e_waddr] <= e_wdata;
		e_rdata <= elem_mem[e_raddr];
		if (p_we) prog_mem[p_waddr] <= p_wdata;
		p_rdata <= prog_mem[e_raddr];
	end

	state_t state_q, state_d;
	in_item_t item_q;
	logic [CountBits-1:0] idx_q;
	logic [4:0]  div_cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] pace_q;
	logic        fast_q;
	logic [15:0] confl_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [NodeBits-1:0] ea_q, eb_q;
	logic [15:0]  step_q;
	logic [NW-1:0] na_q;
	logic        na_phase_q;
	logic        fire_a_q;

	logic last_node, last_elem;
	assign last_node = (idx_q + 1'b1 >= node_count_q) || (idx_q == CountBits'(MaxNodes - 1));
	assign last_elem = (idx_q + 1'b1 >= elem_count_q) || (idx_q == CountBits'(MaxElements - 1));

	// element evaluation on registered node words
	logic a_dep, a_ref, b_dep, b_ref, el_blocked, el_active;
	logic [16:0] prog_sum;
	assign a_dep = na_q[NW-2];
	assign a_ref = na_q[NW-3];
	assign b_dep = n_rdata[NW-2];
	assign b_ref = n_rdata[NW-3];
	assign el_blocked = blk_en_q && (ea_q == blk_node_q || eb_q == blk_node_q);
	assign el_active = !el_blocked && (a_dep ^ b_dep) && (a_ref ^ b_ref);
	assign prog_sum = p_rdata + {1'b0, step_q};

	// divider step
	logic [32:0] rem_sh;
	assign rem_sh = {rem_q[31:0], 1'b0};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				unique case (mode_t'(in_ch.data.mode))
					MODE_LOAD_NODE: state_d = ST_READ_RD;
					MODE_LOAD_ELEM: state_d = ST_DIV;
					MODE_TICK: state_d = (pace_q == '0 && node_count_q != '0)
						? ST_PACE_RD : (elem_count_q != '0 ? ST_EL_RD
						: (node_count_q != '0 ? ST_NODE_RD : ST_OUT));
					MODE_READ: state_d = ST_READ_RD;
					default: ;
				endcase
			end
			ST_CLEAR: if (idx_q == CountBits'(MaxNodes - 1)) state_d = ST_IDLE;
			ST_DIV: if (div_cnt_q == 5'd0) state_d = ST_OUT;
			ST_PACE_RD: state_d = ST_PACE_WR;
			ST_PACE_WR: if (last_node) state_d = elem_count_q != '0 ? ST_EL_RD
				: ST_NODE_RD;
				else state_d = ST_PACE_RD;
			ST_EL_RD: state_d = ST_EL_NODE_RD;
			ST_EL_NODE_RD: state_d = na_phase_q ? ST_EL_EVAL : ST_EL_NODE_RD;
			ST_EL_EVAL: if (el_active && prog_sum >= HitQ16) state_d = ST_EL_FIRE;
				else if (last_elem) state_d = node_count_q != '0 ? ST_NODE_RD : ST_OUT;
				else state_d = ST_EL_RD;
			ST_EL_FIRE: if (last_elem) state_d = node_count_q != '0 ? ST_NODE_RD : ST_OUT;
				else state_d = ST_EL_RD;
			ST_NODE_RD: state_d = ST_NODE_WR;
			ST_NODE_WR: state_d = last_node ? ST_OUT : ST_NODE_RD;
			ST_READ_RD: state_d = ST_READ_WR;
			ST_READ_WR: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		n_we = 1'b0;
		n_addr = idx_q[NodeBits-1:0];
		n_wdata = n_rdata;
		e_we = 1'b0;
		e_waddr = item_q.element_index;
		e_wdata = {item_q.end_a, item_q.end_b, quo_q[31:16] != '0 ? 16'hFFFF : quo_q[15:0]};
		e_raddr = idx_q[ElemBits-1:0];
		p_we = 1'b0;
		p_waddr = idx_q[ElemBits-1:0];
		p_wdata = '0;
		fire_a_q = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				n_we = 1'b1;
				n_wdata = '0;
				p_we = 1'b1;
			end
			// quotient is complete once all 32 divider steps have run
			ST_OUT: if (mode_t'(item_q.mode) == MODE_LOAD_ELEM) begin
				e_we = 1'b1;
				p_we = 1'b1;
				p_waddr = item_q.element_index;
			end
			ST_PACE_WR: if (n_rdata[NW-1] && !n_rdata[NW-2]) begin
				n_we = 1'b1;
				n_wdata = {1'b1, 1'b1, 1'b1, {TimerBits{1'b0}}};
			end
			// end a comes straight from the element word, end b from its register
			ST_EL_NODE_RD: n_addr = na_phase_q ? eb_q : e_rdata[EW-1 -: NodeBits];
			ST_EL_EVAL: begin
				n_addr = eb_q;
				if (el_active) begin
					p_we = 1'b1;
					p_wdata = prog_sum >= HitQ16 ? '0 : prog_sum;
				end
			end
			ST_EL_FIRE: begin
				// n_rdata still holds end b, na_q holds end a
				if (a_dep && !b_ref) begin
					n_addr = eb_q;
					n_we = 1'b1;
					n_wdata = {n_rdata[NW-1], 2'b11, {TimerBits{1'b0}}};
				end else if (b_dep && !a_ref) begin
					n_addr = ea_q;
					n_we = 1'b1;
					n_wdata = {na_q[NW-1], 2'b11, {TimerBits{1'b0}}};
					fire_a_q = 1'b1;
				end
			end
			ST_NODE_WR: begin
				n_we = 1'b1;
				n_wdata = n_rdata;
				if (n_rdata[TimerBits-1:0] > apd_q) n_wdata[NW-2] = 1'b0;
				if (n_rdata[TimerBits-1:0] > erp_q) n_wdata[NW-3] = 1'b0;
				if (n_wdata[NW-3] && n_rdata[TimerBits-1:0] != '1)
					n_wdata[TimerBits-1:0] = n_rdata[TimerBits-1:0] + 1'b1;
			end
			ST_READ_RD: n_addr = item_q.node_index;
			ST_READ_WR: begin
				n_addr = item_q.node_index;
				if (mode_t'(item_q.mode) == MODE_LOAD_NODE) begin
					n_we = 1'b1;
					n_wdata = {item_q.pacing_site, n_rdata[NW-2:0]};
				end
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	logic [16:0] period_eff;
	assign period_eff = (period_q == '0) ? 17'd1 : {1'b0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			pace_q <= '0;
			fast_q <= 1'b0;
			confl_q <= '0;
			out_valid_q <= 1'b0;
			na_phase_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid && in_ch.ready) begin
					idx_q <= '0;
					div_cnt_q <= 5'd31;
					if (mode_t'(in_ch.data.mode) == MODE_TICK)
						pace_q <= ({1'b0, pace_q} + 17'd1 >= period_eff) ? '0
							: pace_q + 1'b1;
					// 10*speed >= 3*length
					if (mode_t'(in_ch.data.mode) == MODE_LOAD_ELEM &&
						{1'b0, speed_q, 3'b0} + {3'b0, speed_q, 1'b0} >=
						{1'b0, in_ch.data.element_length, 1'b0} + {2'b0, in_ch.data.element_length})
						fast_q <= 1'b1;
				end
				ST_CLEAR: idx_q <= idx_q + 1'b1;
				ST_DIV: div_cnt_q <= div_cnt_q - 1'b1;
				ST_PACE_WR: idx_q <= last_node ? '0 : idx_q + 1'b1;
				ST_EL_RD: na_phase_q <= 1'b0;
				ST_EL_NODE_RD: na_phase_q <= 1'b1;
				ST_EL_EVAL: if (!(el_active && prog_sum >= HitQ16))
					idx_q <= last_elem ? '0 : idx_q + 1'b1;
				ST_EL_FIRE: begin
					if (!(a_dep && !b_ref) && !(b_dep && !a_ref) && confl_q != '1)
						confl_q <= confl_q + 1'b1;
					idx_q <= last_elem ? '0 : idx_q + 1'b1;
				end
				ST_NODE_WR: idx_q <= idx_q + 1'b1;
				ST_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				item_q <= in_ch.data;
				rem_q <= '0;
				quo_q <= {speed_q, 16'h0};
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh[31:0] + {31'b0, quo_q[31]} >= {17'b0, item_q.element_length}
					&& item_q.element_length != '0) begin
					rem_q <= {1'b0, rem_sh[31:0] + {31'b0, quo_q[31]}}
						- {17'b0, item_q.element_length};
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {1'b0, rem_sh[31:0] + {31'b0, quo_q[31]}};
					quo_q <= {quo_q[30:0], item_q.element_length == '0};
				end
			end
			ST_EL_RD: ;
			ST_EL_NODE_RD: begin
				if (!na_phase_q) begin
					ea_q <= e_rdata[EW-1 -: NodeBits];
					eb_q <= e_rdata[EW-NodeBits-1 -: NodeBits];
					step_q <= e_rdata[15:0];
				end else na_q <= n_rdata;
			end
			default: ;
		endcase
		if (state_q == ST_READ_WR) begin
			out_q.depolarized <= (mode_t'(item_q.mode) == MODE_READ) & n_rdata[NW-2];
			out_q.refractory <= (mode_t'(item_q.mode) == MODE_READ) & n_rdata[NW-3];
			out_q.timer <= (mode_t'(item_q.mode) == MODE_READ) ? n_rdata[15:0] : '0;
		end else if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			out_q.depolarized <= 1'b0;
			out_q.refractory <= 1'b0;
			out_q.timer <= '0;
		end
		if (state_q == ST_OUT) begin
			out_q.too_fast <= fast_q;
			out_q.conflicts <= confl_q;
		end
		if (fire_a_q) na_q <= na_q;
	end

endmodule

FILE: rtl/core/fea_checker.sv
// ----------------------------------------------------------------------------
// fea_checker
// Port-level checks of the fiber excitation automaton.
// ----------------------------------------------------------------------------
module fea_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_too_fast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_fast_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_too_fast |=> !(out_valid && !out_too_fast))
		else $error("too_fast cleared");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item taken with result pending");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind fiber_excitation_automaton_top fea_checker u_fea_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_too_fast(out_ch.data.too_fast)
);
